### hw/rtl/nkg_pkg.sv
// Shared types and constants for the kanji / grouped-digit number formatter.
// Holds the request structs, symbol codes, mode codes and BCD sizing helper.
// Depends on nothing.
package nkg_pkg;

  localparam int NUMBER_BITS_DEF = 63;
  localparam int MODE_W          = 2;
  localparam int NUMBER_W        = 63;
  localparam int SYMBOL_W        = 5;
  localparam int DIGIT_W         = 4;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_KANJI      = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEP_ASCII  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEP_WIDE   = 2'd2;

  // Symbol codes; digits 0-9 stand for themselves
  localparam logic [SYMBOL_W-1:0] SYM_ZERO     = 5'd0;
  localparam logic [SYMBOL_W-1:0] SYM_TEN      = 5'd10;
  localparam logic [SYMBOL_W-1:0] SYM_HUNDRED  = 5'd11;
  localparam logic [SYMBOL_W-1:0] SYM_THOUSAND = 5'd12;
  localparam logic [SYMBOL_W-1:0] SYM_MAN      = 5'd13;
  localparam logic [SYMBOL_W-1:0] SYM_OKU      = 5'd14;
  localparam logic [SYMBOL_W-1:0] SYM_CHO      = 5'd15;
  localparam logic [SYMBOL_W-1:0] SYM_COMMA    = 5'd16;

  // Kanji numbers use at most sixteen digit places
  localparam int KANJI_DIGITS = 16;
  // Separated modes need at least four digits
  localparam int SEP_MIN_DIGITS = 4;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [NUMBER_W-1:0] number;
  } in_req_t;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                error;
    logic                last;
  } out_req_t;

  // Number of BCD digits kept for a binary value of the given width. Slightly
  // generous, and never below one digit above the kanji range.
  function automatic int bcd_digits(input int bits);
    int n;
    n = (bits * 302) / 1000 + 1;
    if (n < KANJI_DIGITS + 1) begin
      n = KANJI_DIGITS + 1;
    end
    return n;
  endfunction

endpackage

### hw/rtl/number_to_kanji_or_grouped_digits_top.sv
// Top level of the kanji / comma-grouped number formatter.
// Depends on nkg_pkg and nkg_bin2bcd.
//
// Usage:
//   A request on the input channel (in_valid_i / in_ready_o / in_req_i)
//   carries a mode and a number. The block answers with a run of result
//   requests on the output channel (out_valid_o / out_ready_i / out_req_o),
//   most significant symbol first, with last set on the final one. An out
//   of range number (or an unused mode) gives a single request with error
//   and last set and symbol zero.
//   Sequence: the request is taken, the bit-serial BCD converter shifts in
//   all NUMBER_BITS bits and flags it done, and a check state tests the
//   range; an error result then goes straight to the release. Otherwise the
//   scan visits each digit place, with a further step for each emitted unit
//   or comma, and a last step releases the final symbol. The converter shift
//   loop and the digit scan set the run time; the block takes one request
//   at a time.
//   in_ready_o is high only while idle. The final symbol of one request may
//   still wait in the output register while the next request is taken.
//   A stalled receiver holds the output register; the scan then holds as
//   soon as a second symbol is waiting behind it.
//   Reset empties the output register and returns the sequencer to idle.
module number_to_kanji_or_grouped_digits_top #(
  parameter int NUMBER_BITS = nkg_pkg::NUMBER_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  nkg_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output nkg_pkg::out_req_t out_req_o
);
  import nkg_pkg::*;

  localparam int BCD_DIGITS = bcd_digits(NUMBER_BITS);
  localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
  localparam int POS_W      = $clog2(BCD_DIGITS);
  localparam logic [POS_W-1:0] POS_MAX   = POS_W'(BCD_DIGITS - 1);
  localparam logic [POS_W-1:0] POS_KANJI = POS_W'(KANJI_DIGITS);
  localparam logic [1:0]       MOD3_INIT = 2'((BCD_DIGITS - 1) % 3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_CHECK,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e               state_q, state_d;
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [BCD_W-1:0]     dig_q, dig_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [1:0]           mod3_q, mod3_d;
  logic                 sub_q, sub_d;
  logic                 started_q, started_d;
  logic                 grp_nz_q, grp_nz_d;
  logic                 hold_v_q, hold_v_d;
  logic [SYMBOL_W-1:0]  hold_sym_q, hold_sym_d;
  logic                 hold_err_q, hold_err_d;
  logic                 out_v_q, out_v_d;
  out_req_t             out_q, out_d;

  logic                 conv_start;
  logic                 conv_done;
  logic [BCD_W-1:0]     conv_bcd;

  logic [DIGIT_W-1:0]   d;
  logic                 d_nz;
  logic [1:0]           place;
  logic [1:0]           group;
  logic                 emit_d, emit_u, emit;
  logic [SYMBOL_W-1:0]  unit_sym, sym;
  logic                 slot_free;
  logic                 bad;
  logic                 any_nz, hi_nz, ge_1000;

  nkg_bin2bcd #(
    .NUMBER_BITS (NUMBER_BITS),
    .BCD_DIGITS  (BCD_DIGITS)
  ) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (in_req_i.number[NUMBER_BITS-1:0]),
    .done_o  (conv_done),
    .bcd_o   (conv_bcd)
  );

  function automatic logic [SYMBOL_W-1:0] place_unit(input logic [1:0] p);
    case (p)
      2'd1:    return SYM_TEN;
      2'd2:    return SYM_HUNDRED;
      2'd3:    return SYM_THOUSAND;
      default: return SYM_ZERO;
    endcase
  endfunction

  function automatic logic [SYMBOL_W-1:0] group_unit(input logic [1:0] g);
    case (g)
      2'd1:    return SYM_MAN;
      2'd2:    return SYM_OKU;
      2'd3:    return SYM_CHO;
      default: return SYM_ZERO;
    endcase
  endfunction

  // Range checks on the converted value
  assign any_nz  = |conv_bcd;
  assign hi_nz   = |conv_bcd[BCD_W-1:KANJI_DIGITS*DIGIT_W];
  assign ge_1000 = |conv_bcd[BCD_W-1:(SEP_MIN_DIGITS-1)*DIGIT_W];

  always_comb begin
    case (mode_q)
      MODE_KANJI:                    bad = !any_nz || hi_nz;
      MODE_SEP_ASCII, MODE_SEP_WIDE: bad = !ge_1000;
      default:                       bad = 1'b1;
    endcase
  end

  // Symbol decision for the digit place under scan
  assign d     = dig_q[BCD_W-1 -: DIGIT_W];
  assign d_nz  = (d != '0);
  assign place = pos_q[1:0];
  assign group = pos_q[3:2];

  always_comb begin
    emit_d   = 1'b0;
    emit_u   = 1'b0;
    unit_sym = SYM_COMMA;
    if (mode_q == MODE_KANJI) begin
      if (pos_q < POS_KANJI) begin
        if (place != 2'd0) begin
          // digit one is implied by the unit alone
          emit_d   = (d > DIGIT_W'(1));
          emit_u   = d_nz;
          unit_sym = place_unit(place);
        end else begin
          emit_d   = d_nz;
          emit_u   = (group != 2'd0) && (grp_nz_q || d_nz);
          unit_sym = group_unit(group);
        end
      end
    end else begin
      // skip leading zeros, comma before every third place from the right
      emit_d = started_q || d_nz;
      emit_u = (started_q || d_nz) && (pos_q != '0) && (mod3_q == 2'd0);
    end
  end

  assign emit      = sub_q ? emit_u : emit_d;
  assign sym       = sub_q ? unit_sym : {{(SYMBOL_W-DIGIT_W){1'b0}}, d};
  assign slot_free = !out_v_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    dig_d      = dig_q;
    pos_d      = pos_q;
    mod3_d     = mod3_q;
    sub_d      = sub_q;
    started_d  = started_q;
    grp_nz_d   = grp_nz_q;
    hold_v_d   = hold_v_q;
    hold_sym_d = hold_sym_q;
    hold_err_d = hold_err_q;
    out_d      = out_q;
    out_v_d    = out_v_q && !out_ready_i;
    conv_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d     = in_req_i.mode;
          conv_start = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        dig_d     = conv_bcd;
        pos_d     = POS_MAX;
        mod3_d    = MOD3_INIT;
        sub_d     = 1'b0;
        started_d = 1'b0;
        grp_nz_d  = 1'b0;
        if (bad) begin
          hold_v_d   = 1'b1;
          hold_sym_d = SYM_ZERO;
          hold_err_d = 1'b1;
          state_d    = ST_FLUSH;
        end else begin
          hold_v_d = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // hold the scan while a waiting symbol cannot move on
        if (!emit || !hold_v_q || slot_free) begin
          if (emit) begin
            if (hold_v_q) begin
              out_v_d = 1'b1;
              out_d   = '{symbol: hold_sym_q, error: hold_err_q, last: 1'b0};
            end
            hold_v_d   = 1'b1;
            hold_sym_d = sym;
            hold_err_d = 1'b0;
          end
          if (!sub_q && emit_u) begin
            sub_d = 1'b1;
          end else begin
            // advance to the next lower place
            sub_d     = 1'b0;
            dig_d     = {dig_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            pos_d     = pos_q - POS_W'(1);
            mod3_d    = (mod3_q == 2'd0) ? 2'd2 : mod3_q - 2'd1;
            started_d = started_q || d_nz;
            grp_nz_d  = (place == 2'd0) ? 1'b0 : (grp_nz_q || d_nz);
            if (pos_q == '0) begin
              state_d = ST_FLUSH;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          out_v_d  = 1'b1;
          out_d    = '{symbol: hold_sym_q, error: hold_err_q, last: 1'b1};
          hold_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      sub_q     <= 1'b0;
      started_q <= 1'b0;
      grp_nz_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      mode_q     <= mode_d;
      dig_q      <= dig_d;
      pos_q      <= pos_d;
      mod3_q     <= mod3_d;
      sub_q      <= sub_d;
      started_q  <= started_d;
      grp_nz_q   <= grp_nz_d;
      hold_v_q   <= hold_v_d;
      hold_sym_q <= hold_sym_d;
      hold_err_q <= hold_err_d;
      out_v_q    <= out_v_d;
      out_q      <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_req_o   = out_q;

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again before the run finished");

  a_flush_has_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |-> hold_v_q)
    else $error("final release with no symbol waiting");

  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> state_q == ST_CONV)
    else $error("converter finished outside the conversion state");

  a_error_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.error |-> out_req_o.last && out_req_o.symbol == SYM_ZERO)
    else $error("error result is not a lone final zero");

  a_symbol_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.symbol <= SYM_COMMA)
    else $error("symbol code out of range");

endmodule

### hw/rtl/nkg_bin2bcd.sv
// Bit-serial binary to BCD converter (shift-and-add-three), one bit a cycle.
// Depends on nkg_pkg.
module nkg_bin2bcd #(
  parameter int NUMBER_BITS = nkg_pkg::NUMBER_BITS_DEF,
  parameter int BCD_DIGITS  = nkg_pkg::bcd_digits(nkg_pkg::NUMBER_BITS_DEF)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [NUMBER_BITS-1:0]   value_i,
  output logic                     done_o,
  output logic [BCD_DIGITS*nkg_pkg::DIGIT_W-1:0] bcd_o
);
  import nkg_pkg::*;

  localparam int BCD_W = BCD_DIGITS * DIGIT_W;
  localparam int CNT_W = $clog2(NUMBER_BITS);

  logic [NUMBER_BITS-1:0] sr_q;
  logic [BCD_W-1:0]       bcd_q;
  logic [BCD_W-1:0]       adj;
  logic [CNT_W-1:0]       cnt_q;
  logic                   busy_q;
  logic                   done_q;

  // Add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      logic [DIGIT_W-1:0] dig;
      dig = bcd_q[DIGIT_W*i +: DIGIT_W];
      adj[DIGIT_W*i +: DIGIT_W] = (dig >= DIGIT_W'(5)) ? dig + DIGIT_W'(3) : dig;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        bcd_q <= {adj[BCD_W-2:0], sr_q[NUMBER_BITS-1]};
        sr_q  <= {sr_q[NUMBER_BITS-2:0], 1'b0};
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUMBER_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        sr_q   <= value_i;
        bcd_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule
